// ===== hdl/mckd_pkg.sv =====
// ----------------------------------------------------------------------------
// mckd_pkg
// Shared types and constants of the multi-click key detector: register map,
// key phase codes, event codes, click limit, input opcodes and result keys.
// ----------------------------------------------------------------------------
`default_nettype none

package mckd_pkg;

  // configuration register map
  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;
  localparam int REG_W     = 16;

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_ONE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_TWO  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_ONE = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_REPEAT_TWO = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DOUBLE_WIN = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TRIPLE_WIN = 3'd7;

  // register values after reset, in map order
  localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] = '{
    16'd1, 16'd50, 16'd100, 16'd200, 16'd10, 16'd5, 16'd15, 16'd15
  };

  // per-key phase codes as stored in the key state table
  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_DEBOUNCE    = 3'd1,
    PH_PRESSED     = 3'd2,
    PH_WAIT_DOUBLE = 3'd3,
    PH_WAIT_TRIPLE = 3'd4
  } key_phase_t;

  // latched event codes
  localparam int EV_W = 3;
  localparam logic [EV_W-1:0] EV_NONE   = 3'd0;
  localparam logic [EV_W-1:0] EV_CLICK  = 3'd1;
  localparam logic [EV_W-1:0] EV_DOUBLE = 3'd2;
  localparam logic [EV_W-1:0] EV_TRIPLE = 3'd3;
  localparam logic [EV_W-1:0] EV_LONG   = 3'd4;

  // clicks that make a triple click
  localparam logic [2:0] CLICK_LIMIT = 3'd3;

  // input opcodes
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  // keys visible on the result word
  localparam int OUT_KEYS = 4;

endpackage

`default_nettype wire

// ===== hdl/multi_click_key_detector_top.sv =====
// ----------------------------------------------------------------------------
// multi_click_key_detector_top
// Per-key debounce, multi-click and long-press detector. One key state entry
// is updated per cycle by a shared step unit while no remainder is running;
// long-press repeat points are checked by a shared bit-serial remainder unit.
// ----------------------------------------------------------------------------
// Sequence: a read item goes from idle straight to the done state; a scan
//   tick steps through every key and runs the remainder unit for every key
//   that needs a repeat-point remainder; a stalled output register adds its wait.
// Throughput: one item at a time; ready returns as the result is loaded.
// Reset: synchronous rst loads register defaults, idles keys, clears counts.
`default_nettype none

module multi_click_key_detector_top #(
  parameter int KEY_COUNT   = 4,
  parameter int COUNT_BITS  = 16,
  parameter int FAST_REPEAT = 1
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [3:0] pressed_mask, [7:4] read_count
  input  wire logic [0:0]  s_tuser,   // [0] opcode
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [2:0] event_key0, [5:3] event_key1,
                                      // [8:6] event_key2, [11:9] event_key3
  // configuration writes
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int KEY_BITS = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
  localparam int CMP_W    = (COUNT_BITS > mckd_pkg::REG_W) ? COUNT_BITS : mckd_pkg::REG_W;
  localparam int CNT_W    = $clog2(COUNT_BITS);
  localparam int RD_KEYS  = (KEY_COUNT < mckd_pkg::OUT_KEYS) ? KEY_COUNT : mckd_pkg::OUT_KEYS;
  localparam int SP_W     = mckd_pkg::REG_W;

  typedef enum logic [3:0] {
    SQ_IDLE = 4'b0001,
    SQ_SCAN = 4'b0010,
    SQ_MOD  = 4'b0100,
    SQ_DONE = 4'b1000
  } seq_state_t;

  seq_state_t seq_state;

  // configuration registers
  logic [mckd_pkg::REG_W-1:0] cfg_regs [mckd_pkg::REG_COUNT];

  // key state table
  mckd_pkg::key_phase_t         phase    [KEY_COUNT];
  logic [COUNT_BITS-1:0]        hold_cnt [KEY_COUNT];
  logic [COUNT_BITS-1:0]        rel_cnt  [KEY_COUNT];
  logic [mckd_pkg::EV_W-1:0]    pend_ev  [KEY_COUNT];
  logic [1:0]                   step     [KEY_COUNT];
  logic [KEY_COUNT-1:0]         prev_lvl;

  // sequencer registers
  logic [KEY_BITS-1:0]          key;
  logic [3:0]                   mask;
  logic [11:0]                  res;

  // remainder unit registers
  logic [COUNT_BITS-1:0]        div_q;
  logic [SP_W-1:0]              div_rem;
  logic [SP_W-1:0]              div_d;
  logic [CNT_W-1:0]             div_cnt;

  // input fields
  logic                         in_op;
  logic [3:0]                   in_mask;
  logic [3:0]                   in_count;
  logic                         in_xfer;
  logic                         read_ok;

  assign in_op    = s_tuser[0];
  assign in_mask  = s_tdata[3:0];
  assign in_count = s_tdata[7:4];
  assign in_xfer  = s_tvalid && s_tready;
  assign s_tready = (seq_state == SQ_IDLE);
  assign read_ok  = ({1'b0, in_count} <= 5'(KEY_COUNT));

  // key levels, keys past the mask seen as released
  logic [KEY_COUNT-1:0] level_vec;
  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      level_vec[k] = (k < 4) ? mask[k % 4] : 1'b0;
    end
  end

  // read result of the first keys
  logic [11:0] read_res;
  always_comb begin
    read_res = '0;
    for (int k = 0; k < RD_KEYS; k++) begin
      if (read_ok && (4'(k) < in_count)) begin
        read_res[3*k +: 3] = pend_ev[k];
      end
    end
  end

  // shared key step unit
  mckd_pkg::key_phase_t       cur_ph;
  logic [COUNT_BITS-1:0]      cur_h;
  logic [COUNT_BITS-1:0]      cur_r;
  logic [1:0]                 cur_s;
  logic                       lvl;
  logic                       press_edge;
  logic [COUNT_BITS-1:0]      h_inc;
  logic [COUNT_BITS-1:0]      r_inc;
  mckd_pkg::key_phase_t       ph_n;
  logic [COUNT_BITS-1:0]      hold_n;
  logic [COUNT_BITS-1:0]      rel_n;
  logic [1:0]                 step_n;
  logic                       ev_we;
  logic [mckd_pkg::EV_W-1:0]  ev_n;
  logic                       mod_go;
  logic [COUNT_BITS-1:0]      mod_dividend;
  logic [SP_W-1:0]            mod_spacing;

  always_comb begin
    logic [2:0]       step_sum;
    logic [CMP_W-1:0] t_ext;
    logic [CMP_W-1:0] start_ext;
    logic [CMP_W-1:0] in_phase;
    logic [SP_W-1:0]  win;

    cur_ph     = phase[key];
    cur_h      = hold_cnt[key];
    cur_r      = rel_cnt[key];
    cur_s      = step[key];
    lvl        = level_vec[key];
    press_edge = lvl && !prev_lvl[key];
    h_inc      = (cur_h == '1) ? cur_h : cur_h + 1'b1;
    r_inc      = (cur_r == '1) ? cur_r : cur_r + 1'b1;

    ph_n         = cur_ph;
    hold_n       = cur_h;
    rel_n        = cur_r;
    step_n       = cur_s;
    ev_we        = 1'b0;
    ev_n         = mckd_pkg::EV_NONE;
    mod_go       = 1'b0;
    step_sum     = {1'b0, cur_s} + 3'd1;
    t_ext        = CMP_W'(h_inc);
    start_ext    = CMP_W'(cfg_regs[mckd_pkg::REG_LONG_PRESS]);
    mod_spacing  = cfg_regs[mckd_pkg::REG_REPEAT_ONE];
    win          = cfg_regs[mckd_pkg::REG_DOUBLE_WIN];

    // repeat phase selection for the long-press check
    if (t_ext >= CMP_W'(cfg_regs[mckd_pkg::REG_PHASE_TWO])) begin
      start_ext   = CMP_W'(cfg_regs[mckd_pkg::REG_PHASE_TWO]);
      mod_spacing = SP_W'(FAST_REPEAT);
    end else if (t_ext >= CMP_W'(cfg_regs[mckd_pkg::REG_PHASE_ONE])) begin
      start_ext   = CMP_W'(cfg_regs[mckd_pkg::REG_PHASE_ONE]);
      mod_spacing = cfg_regs[mckd_pkg::REG_REPEAT_TWO];
    end
    in_phase     = t_ext - start_ext;
    mod_dividend = in_phase[COUNT_BITS-1:0];

    case (cur_ph) inside
      mckd_pkg::PH_DEBOUNCE: begin
        hold_n = h_inc;
        if (t_ext >= CMP_W'(cfg_regs[mckd_pkg::REG_DEBOUNCE])) begin
          if (lvl) begin
            ph_n   = mckd_pkg::PH_PRESSED;
            hold_n = '0;
          end else begin
            ph_n = mckd_pkg::PH_IDLE;
          end
        end
      end
      mckd_pkg::PH_PRESSED: begin
        if (!lvl) begin
          hold_n = '0;
          if (CMP_W'(cur_h) < CMP_W'(cfg_regs[mckd_pkg::REG_LONG_PRESS])) begin
            if (step_sum >= mckd_pkg::CLICK_LIMIT) begin
              ev_we  = 1'b1;
              ev_n   = mckd_pkg::EV_TRIPLE;
              ph_n   = mckd_pkg::PH_IDLE;
              step_n = '0;
            end else begin
              ph_n   = (step_sum == 3'd1) ? mckd_pkg::PH_WAIT_DOUBLE
                                          : mckd_pkg::PH_WAIT_TRIPLE;
              step_n = step_sum[1:0];
              rel_n  = '0;
            end
          end else begin
            ph_n   = mckd_pkg::PH_IDLE;
            step_n = '0;
          end
        end else begin
          hold_n = h_inc;
          // long press: first tick of a phase fires at once, others need a remainder
          if (t_ext >= CMP_W'(cfg_regs[mckd_pkg::REG_LONG_PRESS])) begin
            if (in_phase == '0) begin
              ev_we = 1'b1;
              ev_n  = mckd_pkg::EV_LONG;
            end else if (mod_spacing != '0) begin
              mod_go = 1'b1;
            end
          end
        end
      end
      mckd_pkg::PH_WAIT_DOUBLE, mckd_pkg::PH_WAIT_TRIPLE: begin
        rel_n = r_inc;
        if (cur_ph == mckd_pkg::PH_WAIT_TRIPLE) begin
          win = cfg_regs[mckd_pkg::REG_TRIPLE_WIN];
        end
        if (CMP_W'(r_inc) >= CMP_W'(win)) begin
          ev_we  = 1'b1;
          ev_n   = (cur_ph == mckd_pkg::PH_WAIT_DOUBLE) ? mckd_pkg::EV_CLICK
                                                       : mckd_pkg::EV_DOUBLE;
          ph_n   = mckd_pkg::PH_IDLE;
          step_n = '0;
        end else if (press_edge) begin
          ph_n   = mckd_pkg::PH_DEBOUNCE;
          hold_n = '0;
        end
      end
      default: begin
        ph_n = mckd_pkg::PH_IDLE;
        if (press_edge) begin
          ph_n   = mckd_pkg::PH_DEBOUNCE;
          hold_n = '0;
        end
      end
    endcase
  end

  // remainder unit, one dividend bit per cycle
  logic [SP_W:0]   div_shift;
  logic            div_ge;
  logic [SP_W-1:0] rem_next;

  assign div_shift = {div_rem, div_q[COUNT_BITS-1]};
  assign div_ge    = (div_shift >= {1'b0, div_d});
  always_comb begin
    logic [SP_W:0] diff;
    diff     = div_shift - {1'b0, div_d};
    rem_next = div_ge ? diff[SP_W-1:0] : div_shift[SP_W-1:0];
  end

  logic last_key;
  assign last_key = (key == KEY_BITS'(KEY_COUNT - 1));

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mckd_pkg::REG_COUNT; i++) begin
        cfg_regs[i] <= mckd_pkg::REG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // sequencer and key state table
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_state <= SQ_IDLE;
      key       <= '0;
      m_tvalid  <= 1'b0;
      prev_lvl  <= '0;
      for (int k = 0; k < KEY_COUNT; k++) begin
        phase[k]    <= mckd_pkg::PH_IDLE;
        hold_cnt[k] <= '0;
        rel_cnt[k]  <= '0;
        pend_ev[k]  <= mckd_pkg::EV_NONE;
        step[k]     <= '0;
      end
    end else begin
      // drop valid after a transfer out unless a new result is loaded
      if (m_tvalid && m_tready && (seq_state != SQ_DONE)) begin
        m_tvalid <= 1'b0;
      end
      unique case (seq_state)
        SQ_IDLE: begin
          if (in_xfer) begin
            mask <= in_mask;
            key  <= '0;
            if (in_op == mckd_pkg::OP_SCAN) begin
              res       <= '0;
              seq_state <= SQ_SCAN;
            end else begin
              // read and clear latched events
              res <= read_res;
              for (int k = 0; k < KEY_COUNT; k++) begin
                if (read_ok && (5'(k) < {1'b0, in_count})) begin
                  pend_ev[k] <= mckd_pkg::EV_NONE;
                end
              end
              seq_state <= SQ_DONE;
            end
          end
        end
        SQ_SCAN: begin
          phase[key]    <= ph_n;
          hold_cnt[key] <= hold_n;
          rel_cnt[key]  <= rel_n;
          step[key]     <= step_n;
          prev_lvl[key] <= lvl;
          if (ev_we) begin
            pend_ev[key] <= ev_n;
          end
          if (mod_go) begin
            div_q     <= mod_dividend;
            div_rem   <= '0;
            div_d     <= mod_spacing;
            div_cnt   <= CNT_W'(COUNT_BITS - 1);
            seq_state <= SQ_MOD;
          end else if (last_key) begin
            seq_state <= SQ_DONE;
          end else begin
            key <= key + 1'b1;
          end
        end
        SQ_MOD: begin
          div_rem <= rem_next;
          div_q   <= {div_q[COUNT_BITS-2:0], 1'b0};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            if (rem_next == '0) begin
              pend_ev[key] <= mckd_pkg::EV_LONG;
            end
            if (last_key) begin
              seq_state <= SQ_DONE;
            end else begin
              key       <= key + 1'b1;
              seq_state <= SQ_SCAN;
            end
          end
        end
        SQ_DONE: begin
          // hand the result to the output register once it is free
          if (!m_tvalid || m_tready) begin
            m_tvalid  <= 1'b1;
            m_tdata   <= {4'b0, res};
            seq_state <= SQ_IDLE;
          end
        end
        default: begin
          seq_state <= SQ_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mckd_checker.sv =====
// ----------------------------------------------------------------------------
// mckd_checker
// Port-level checks of the multi-click key detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mckd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // items accepted whose result is not yet transferred
  logic [2:0] open_items;
  always_ff @(posedge clk) begin
    if (rst) begin
      open_items <= '0;
    end else begin
      open_items <= open_items + 3'(s_tvalid && s_tready) - 3'(m_tvalid && m_tready);
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // one item at a time: ready drops after a transfer in
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while busy");

  // no result without an item behind it
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> open_items != 3'd0)
    else $error("result without accepted item");

  // at most one finished and one working item
  a_open_bound: assert property (@(posedge clk) disable iff (rst)
    open_items <= 3'd2)
    else $error("too many items in flight");

  // event codes stay within their encoding, padding is zero
  a_event_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= mckd_pkg::EV_LONG && m_tdata[5:3] <= mckd_pkg::EV_LONG
      && m_tdata[8:6] <= mckd_pkg::EV_LONG && m_tdata[11:9] <= mckd_pkg::EV_LONG
      && m_tdata[15:12] == 4'b0)
    else $error("event code out of range");

endmodule

bind multi_click_key_detector_top mckd_checker u_mckd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== verif/multi_click_key_detector_top_test.sv =====
// ----------------------------------------------------------------------------
// multi_click_key_detector_top_test
// Self-checking bench for the multi-click key detector. Scan ticks and read
// transfers go in through the input stream, and latched key events come back
// on the result stream. Each result is checked against a behavioral model of
// the four key state machines. The model covers debounce, click counting,
// long-press repeat phases, counter saturation and read-and-clear.
// ----------------------------------------------------------------------------
module multi_click_key_detector_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEYS            = mckd_pkg::OUT_KEYS;
  localparam int STALL_LIMIT     = 3000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int END_WAIT        = 100;
  localparam int MAX_REPORTS     = 30;
  localparam int PHASE3_SPACING  = 1;

  // one input item as queued for the driver
  typedef struct packed {
    logic       wait_mark;  // driver holds off until every result is back
    logic       op;
    logic [3:0] mask;
    logic [3:0] count;
  } key_item_t;

  typedef logic [KEYS-1:0][mckd_pkg::EV_W-1:0]                 key_events_t;
  typedef logic [mckd_pkg::REG_COUNT-1:0][mckd_pkg::REG_W-1:0] key_cfg_t;

  // dut connections
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = '0;   // [3:0] pressed_mask, [7:4] read_count
  logic [0:0]  s_tuser   = '0;   // [0] opcode
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;          // [2:0] key0, [5:3] key1, [8:6] key2, [11:9] key3
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data  = '0;

  // stimulus and expected results
  key_item_t   stim_q[$];
  key_events_t expected_events_q[$];
  logic [3:0]  plan[$];
  key_item_t   in_flight;

  // model of the key machines
  logic [mckd_pkg::REG_W-1:0] cfg_shadow [mckd_pkg::REG_COUNT];
  mckd_pkg::key_phase_t       ks_phase   [KEYS];
  logic [15:0]                ks_hold    [KEYS];
  logic [15:0]                ks_release [KEYS];
  logic [mckd_pkg::EV_W-1:0]  ks_event   [KEYS];
  logic [1:0]                 ks_clicks  [KEYS];
  logic                       ks_level   [KEYS];

  // run control and statistics
  int src_gap_pct = 0;
  int snk_gap_pct = 0;
  int hold_reqs   = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int n_sent      = 0;
  int n_reads     = 0;
  int n_results   = 0;
  int n_fail      = 0;
  int quiet_cycles = 0;
  int ev_seen [5];

  multi_click_key_detector_top uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // key machine model
  // ---------------------------------------------------------------------------
  function automatic logic [15:0] sat_bump(logic [15:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  // latch a long press on a repeat point of the current phase
  function automatic void check_long_repeat(int k);
    int unsigned t, start, spacing, offs;
    t = ks_hold[k];
    if (t < cfg_shadow[mckd_pkg::REG_LONG_PRESS]) return;
    if (t < cfg_shadow[mckd_pkg::REG_PHASE_ONE]) begin
      start   = cfg_shadow[mckd_pkg::REG_LONG_PRESS];
      spacing = cfg_shadow[mckd_pkg::REG_REPEAT_ONE];
    end else if (t < cfg_shadow[mckd_pkg::REG_PHASE_TWO]) begin
      start   = cfg_shadow[mckd_pkg::REG_PHASE_ONE];
      spacing = cfg_shadow[mckd_pkg::REG_REPEAT_TWO];
    end else begin
      start   = cfg_shadow[mckd_pkg::REG_PHASE_TWO];
      spacing = PHASE3_SPACING;
    end
    offs = t - start;
    if (offs == 0 || (spacing != 0 && offs % spacing == 0)) ks_event[k] = mckd_pkg::EV_LONG;
  endfunction

  function automatic void scan_key(int k, logic lvl);
    logic       rise;
    logic [2:0] steps;
    logic       first_wait;
    rise = lvl && !ks_level[k];
    case (ks_phase[k])
      mckd_pkg::PH_DEBOUNCE: begin
        ks_hold[k] = sat_bump(ks_hold[k]);
        if (ks_hold[k] >= cfg_shadow[mckd_pkg::REG_DEBOUNCE]) begin
          if (lvl) begin
            ks_phase[k] = mckd_pkg::PH_PRESSED;
            ks_hold[k]  = '0;
          end else begin
            ks_phase[k] = mckd_pkg::PH_IDLE;
          end
        end
      end
      mckd_pkg::PH_PRESSED: begin
        if (!lvl) begin
          if (ks_hold[k] < cfg_shadow[mckd_pkg::REG_LONG_PRESS]) begin
            steps = 3'(ks_clicks[k]) + 3'd1;
            if (steps >= mckd_pkg::CLICK_LIMIT) begin
              ks_event[k]  = mckd_pkg::EV_TRIPLE;
              ks_phase[k]  = mckd_pkg::PH_IDLE;
              ks_clicks[k] = '0;
            end else begin
              ks_clicks[k] = steps[1:0];
              if (steps == 3'd1) ks_phase[k] = mckd_pkg::PH_WAIT_DOUBLE;
              else ks_phase[k] = mckd_pkg::PH_WAIT_TRIPLE;
              ks_release[k] = '0;
            end
          end else begin
            ks_phase[k]  = mckd_pkg::PH_IDLE;
            ks_clicks[k] = '0;
          end
          ks_hold[k] = '0;
        end else begin
          ks_hold[k] = sat_bump(ks_hold[k]);
          check_long_repeat(k);
        end
      end
      mckd_pkg::PH_WAIT_DOUBLE, mckd_pkg::PH_WAIT_TRIPLE: begin
        first_wait    = (ks_phase[k] == mckd_pkg::PH_WAIT_DOUBLE);
        ks_release[k] = sat_bump(ks_release[k]);
        if (ks_release[k] >= cfg_shadow[first_wait ? mckd_pkg::REG_DOUBLE_WIN
                                                   : mckd_pkg::REG_TRIPLE_WIN]) begin
          ks_event[k]  = first_wait ? mckd_pkg::EV_CLICK : mckd_pkg::EV_DOUBLE;
          ks_phase[k]  = mckd_pkg::PH_IDLE;
          ks_clicks[k] = '0;
        end else if (rise) begin
          ks_phase[k] = mckd_pkg::PH_DEBOUNCE;
          ks_hold[k]  = '0;
        end
      end
      default: begin
        ks_phase[k] = mckd_pkg::PH_IDLE;
        if (rise) begin
          ks_phase[k] = mckd_pkg::PH_DEBOUNCE;
          ks_hold[k]  = '0;
        end
      end
    endcase
    ks_level[k] = lvl;
  endfunction

  // advance the model by one item and return the events it reports
  function automatic key_events_t predict_events(key_item_t it);
    key_events_t res;
    res = '0;
    if (it.op == mckd_pkg::OP_SCAN) begin
      for (int k = 0; k < KEYS; k++) scan_key(k, it.mask[k]);
    end else if (it.count <= KEYS) begin
      for (int k = 0; k < KEYS; k++) begin
        if (k < it.count) begin
          res[k]      = ks_event[k];
          ks_event[k] = mckd_pkg::EV_NONE;
        end
      end
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // input driver
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_input
    key_item_t nxt;
    logic      offer;
    offer = 1'b0;
    nxt   = '0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_events_q.push_back(predict_events(in_flight));
        n_sent++;
        if (in_flight.op == mckd_pkg::OP_READ) n_reads++;
      end
      if (!s_tvalid || s_tready) begin
        // a wait mark is dropped once the block has nothing outstanding
        if (stim_q.size() > 0 && stim_q[0].wait_mark && expected_events_q.size() == 0)
          nxt = stim_q.pop_front();
        if (stim_q.size() > 0 && !stim_q[0].wait_mark &&
            $urandom_range(0, 99) >= src_gap_pct) begin
          nxt   = stim_q.pop_front();
          offer = 1'b1;
        end
        if (offer) begin
          in_flight = nxt;
          s_tdata  <= {nxt.count, nxt.mask};
          s_tuser  <= nxt.op;
        end
        s_tvalid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and ready control
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_output
    key_events_t want;
    logic [2:0]  got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        n_results++;
        if (expected_events_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t ns: result transfer with none expected, expected nothing, got %h",
                     $time, m_tdata);
        end else begin
          want = expected_events_q.pop_front();
          for (int k = 0; k < KEYS; k++) begin
            got = m_tdata[3*k +: 3];
            if (got !== want[k]) begin
              n_fail++;
              if (n_fail <= MAX_REPORTS)
                $display("%0t ns: key %0d event mismatch, expected %0d, got %0d",
                         $time, k, want[k], got);
            end else if (got != mckd_pkg::EV_NONE) begin
              ev_seen[got]++;
            end
          end
        end
      end
      // long hold-off on request, random stalls otherwise
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        hold_left   = HOLD_OFF_CYCLES;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= snk_gap_pct);
      end
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin : watchdog
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_item(input logic op, input logic [3:0] mask,
                            input logic [3:0] count, input logic mark);
    key_item_t it;
    it.wait_mark = mark;
    it.op        = op;
    it.mask      = mask;
    it.count     = count;
    stim_q.push_back(it);
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic wait_idle();
    do @(negedge clk);
    while (stim_q.size() != 0 || s_tvalid || expected_events_q.size() != 0);
  endtask

  task automatic apply_config(input key_cfg_t v);
    wait_idle();
    for (int i = 0; i < mckd_pkg::REG_COUNT; i++) begin
      @(posedge clk);
      cfg_we        <= 1'b1;
      cfg_index     <= mckd_pkg::REG_IDX_W'(i);
      cfg_data      <= v[i];
      cfg_shadow[i]  = v[i];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic key_cfg_t pick_small_config();
    key_cfg_t v;
    v = '0;
    v[mckd_pkg::REG_DEBOUNCE]   = 16'($urandom_range(1, 4));
    v[mckd_pkg::REG_LONG_PRESS] = 16'($urandom_range(2, 12));
    v[mckd_pkg::REG_PHASE_ONE]  = v[mckd_pkg::REG_LONG_PRESS] + 16'($urandom_range(0, 10));
    v[mckd_pkg::REG_PHASE_TWO]  = v[mckd_pkg::REG_PHASE_ONE] + 16'($urandom_range(0, 10));
    v[mckd_pkg::REG_REPEAT_ONE] = 16'($urandom_range(1, 4));
    v[mckd_pkg::REG_REPEAT_TWO] = 16'($urandom_range(1, 3));
    v[mckd_pkg::REG_DOUBLE_WIN] = 16'($urandom_range(2, 8));
    v[mckd_pkg::REG_TRIPLE_WIN] = 16'($urandom_range(2, 8));
    return v;
  endfunction

  function automatic int clip(int v, int hi);
    return (v > hi) ? hi : v;
  endfunction

  // set one key's level over a run of ticks in the plan
  task automatic put_run(input int k, inout int pos, input logic lvl, input int len);
    logic [3:0] m;
    repeat (len) begin
      while (plan.size() <= pos) plan.push_back(4'h0);
      m       = plan[pos];
      m[k]    = lvl;
      plan[pos] = m;
      pos++;
    end
  endtask

  // gestures of one key, timed against the current settings
  task automatic plan_key(input int k, input int budget);
    int pos, kind, n, press, gap, win, d, l, w2, w3, span;
    pos  = 0;
    d    = clip(cfg_shadow[mckd_pkg::REG_DEBOUNCE], 40);
    l    = clip(cfg_shadow[mckd_pkg::REG_LONG_PRESS], 300);
    w2   = clip(cfg_shadow[mckd_pkg::REG_DOUBLE_WIN], 40);
    w3   = clip(cfg_shadow[mckd_pkg::REG_TRIPLE_WIN], 40);
    span = int'(cfg_shadow[mckd_pkg::REG_PHASE_TWO]) - l;
    if (span < 0) span = 0;
    span = clip(span + 12, 250);
    while (pos < budget) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        // train of one to four clicks, some too short to pass debounce
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 7) == 0) press = $urandom_range(1, d + 1);
          else press = d + 1 + $urandom_range(0, l - 1);
          put_run(k, pos, 1'b1, press);
          win = (i == 0) ? w2 : w3;
          gap = (i == n - 1) ? win + 2 : $urandom_range(1, win + 1);
          put_run(k, pos, 1'b0, gap);
        end
      end else if (kind < 8) begin
        // hold into the repeat phases
        press = d + 1 + l + $urandom_range(0, span);
        put_run(k, pos, 1'b1, press);
        put_run(k, pos, 1'b0, $urandom_range(2, 5));
      end else begin
        // chatter
        repeat ($urandom_range(1, 6)) put_run(k, pos, 1'($urandom_range(0, 1)), 1);
      end
    end
  endtask

  // random gestures on all keys, reads sprinkled in, one wait mark
  task automatic run_gestures(input int budget);
    int         cut;
    logic [3:0] cnt;
    plan.delete();
    for (int k = 0; k < KEYS; k++) plan_key(k, budget);
    cut = $urandom_range(0, plan.size() - 1);
    foreach (plan[i]) begin
      queue_item(mckd_pkg::OP_SCAN, plan[i], 4'($urandom_range(0, 15)), 1'b0);
      if ($urandom_range(0, 7) == 0) begin
        if ($urandom_range(0, 9) == 0) cnt = 4'($urandom_range(5, 15));
        else cnt = 4'($urandom_range(0, 4));
        queue_item(mckd_pkg::OP_READ, 4'($urandom_range(0, 15)), cnt, 1'b0);
      end
      if (i == cut) queue_item(mckd_pkg::OP_SCAN, 4'h0, 4'h0, 1'b1);
    end
    queue_item(mckd_pkg::OP_READ, 4'($urandom_range(0, 15)), 4'd4, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  // key0 triple click, key1 double click, key2 click then a failed debounce,
  // key3 held through all three repeat phases
  localparam logic [0:11][3:0] DIRECTED_MASKS = {
    4'hF, 4'hF, 4'h8, 4'hF, 4'hB, 4'h8, 4'h9, 4'h9, 4'h8, 4'h8, 4'h8, 4'h0
  };

  initial begin : run_test
    key_cfg_t v;
    for (int i = 0; i < mckd_pkg::REG_COUNT; i++) cfg_shadow[i] = mckd_pkg::REG_RESET[i];
    for (int k = 0; k < KEYS; k++) begin
      ks_phase[k]   = mckd_pkg::PH_IDLE;
      ks_hold[k]    = '0;
      ks_release[k] = '0;
      ks_event[k]   = mckd_pkg::EV_NONE;
      ks_clicks[k]  = '0;
      ks_level[k]   = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // sender rarely idle, receiver mostly stalled
    src_gap_pct = 14;
    snk_gap_pct = 83;

    // reads straight after reset, including an out of range count
    queue_item(mckd_pkg::OP_READ, 4'hF, 4'd4, 1'b0);
    queue_item(mckd_pkg::OP_READ, 4'h0, 4'd15, 1'b0);
    queue_item(mckd_pkg::OP_READ, 4'hA, 4'd0, 1'b0);

    // short timings, zero spacing in phase two
    v = '0;
    v[mckd_pkg::REG_DEBOUNCE]   = 16'd1;
    v[mckd_pkg::REG_LONG_PRESS] = 16'd3;
    v[mckd_pkg::REG_PHASE_ONE]  = 16'd5;
    v[mckd_pkg::REG_PHASE_TWO]  = 16'd6;
    v[mckd_pkg::REG_REPEAT_ONE] = 16'd2;
    v[mckd_pkg::REG_REPEAT_TWO] = 16'd0;
    v[mckd_pkg::REG_DOUBLE_WIN] = 16'd2;
    v[mckd_pkg::REG_TRIPLE_WIN] = 16'd3;
    apply_config(v);
    for (int i = 0; i < 12; i++) begin
      queue_item(mckd_pkg::OP_SCAN, DIRECTED_MASKS[i], 4'(i), 1'b0);
      if (i == 4) queue_item(mckd_pkg::OP_READ, 4'h5, 4'd2, 1'b0);
      if (i == 8) queue_item(mckd_pkg::OP_READ, 4'h0, 4'd4, 1'b0);
    end
    queue_item(mckd_pkg::OP_READ, 4'hF, 4'd5, 1'b0);
    queue_item(mckd_pkg::OP_READ, 4'h3, 4'd15, 1'b0);
    queue_item(mckd_pkg::OP_READ, 4'hC, 4'd4, 1'b0);
    queue_item(mckd_pkg::OP_READ, 4'h0, 4'd3, 1'b0);

    // default timings, with a long receiver hold-off while items keep coming
    for (int i = 0; i < mckd_pkg::REG_COUNT; i++) v[i] = mckd_pkg::REG_RESET[i];
    apply_config(v);
    hold_reqs++;
    run_gestures(150);

    // sender mostly idle, receiver rarely stalled
    wait_idle();
    src_gap_pct = 83;
    snk_gap_pct = 14;
    apply_config(pick_small_config());
    run_gestures(90);
    for (int i = 0; i < mckd_pkg::REG_COUNT; i++) v[i] = 16'd1;
    apply_config(v);
    run_gestures(60);

    // no idling from here on
    wait_idle();
    src_gap_pct = 0;
    snk_gap_pct = 0;
    v = pick_small_config();
    v[mckd_pkg::REG_REPEAT_ONE] = 16'd0;
    v[mckd_pkg::REG_REPEAT_TWO] = 16'd0;
    apply_config(v);
    run_gestures(60);
    v = pick_small_config();
    v[mckd_pkg::REG_DEBOUNCE] = 16'hFFFF;
    apply_config(v);
    run_gestures(20);

    // drain and settle
    wait_idle();
    repeat (END_WAIT) @(posedge clk);
    if (expected_events_q.size() != 0) begin
      n_fail++;
      $display("%0t ns: %0d results never arrived", $time, expected_events_q.size());
    end
    $display("covered %0d input transfers (%0d reads) and %0d result transfers, %0d errors",
             n_sent, n_reads, n_results, n_fail);
    $display("events seen: click %0d, double %0d, triple %0d, long press %0d",
             ev_seen[mckd_pkg::EV_CLICK], ev_seen[mckd_pkg::EV_DOUBLE],
             ev_seen[mckd_pkg::EV_TRIPLE], ev_seen[mckd_pkg::EV_LONG]);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== multi_click_key_detector_top.f =====
hdl/mckd_pkg.sv
hdl/multi_click_key_detector_top.sv
hdl/mckd_checker.sv
verif/multi_click_key_detector_top_test.sv
